>>> hdl/assert_macros.svh
// Assertion helpers shared by the sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Types and constants of the heightmap tile sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_EDIT  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_RD4,
      ST_MULA,
      ST_MULB,
      ST_SUMAB,
      ST_MULT,
      ST_DONE
   } state_type;

   // register indexes of the configuration port
   localparam logic [1:0] REG_ORIGIN_X = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Z = 2'd1;
   localparam logic [1:0] REG_SPACING  = 2'd2;

   // one classified item as it waits in the queue
   typedef struct packed {
      op_type             op;
      logic [6:0]         row;
      logic [6:0]         col;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_z;
      logic signed [23:0] level;
      logic               wr_ok;
   } item_type;

endpackage

>>> hdl/hts_ram.sv
// ----------------------------------------------------------------------------
// hts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4225
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front
// Accepts request words, checks write indexes and queues them for the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hts_front #(
   parameter int GRID_CELLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // grid_row[6:0], grid_col[13:7], pos_x[37:14], pos_z[61:38], level[85:62]
   input  logic [87:0]       req_tdata,
   // opcode[1:0]
   input  logic [1:0]        req_tuser,
   output logic              q_valid,
   input  logic              q_pop,
   output hts_pkg::item_type q_item
);

   localparam int QDEPTH = 2;
   localparam int PW     = $clog2(QDEPTH);

   hts_pkg::item_type item;
   hts_pkg::item_type entry_ff [QDEPTH];
   logic [PW-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              push;

   // classify the incoming word
   always_comb begin
      item.op    = hts_pkg::op_type'(req_tuser);
      item.row   = req_tdata[6:0];
      item.col   = req_tdata[13:7];
      item.pos_x = req_tdata[37:14];
      item.pos_z = req_tdata[61:38];
      item.level = req_tdata[85:62];
      item.wr_ok = (item.op == hts_pkg::OP_WRITE)
                && ({2'b00, item.row} <= 9'(GRID_CELLS))
                && ({2'b00, item.col} <= 9'(GRID_CELLS));
   end

   assign req_tready = (count_ff != (PW+1)'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rptr_ff];

   // advance pointers and fill level
   always_comb begin
      wptr_in  = push  ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in  = q_pop ? rptr_ff + PW'(1) : rptr_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= item;
      end
   end

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= (PW+1)'(QDEPTH), "queue overfilled")
   `ASSERT_IMPL(a_pop_nonempty, clock, reset, q_pop, count_ff != '0, "pop from empty queue")

endmodule

>>> hdl/hts_back.sv
// ----------------------------------------------------------------------------
// hts_back
// Executes queued items: grid writes, edits and bilinear height queries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hts_back #(
   parameter int GRID_CELLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [23:0] origin_x,
   input  logic signed [23:0] origin_z,
   input  logic [15:0]        spacing,
   input  logic               q_valid,
   output logic               q_pop,
   input  hts_pkg::item_type  q_item,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // height_out[23:0], highest[47:24], lowest[71:48]
   output logic [71:0]        rsp_tdata,
   // hit[0]
   output logic               rsp_tuser
);

   localparam int SIDE  = GRID_CELLS + 1;
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int IDXW  = $clog2(SIDE);
   localparam int QW    = IDXW + 16;
   localparam int CW    = $clog2(QW + 1);

   hts_pkg::state_type state_ff, state_in;
   hts_pkg::op_type    op_ff, op_in;
   logic signed [23:0] lvl_ff, lvl_in;
   logic [24:0]        dx_ff, dx_in, dz_ff, dz_in;
   logic [15:0]        remx_ff, remx_in, remz_ff, remz_in;
   logic [QW-1:0]      shx_ff, shx_in, shz_ff, shz_in;
   logic [QW-1:0]      qx_ff, qx_in, qz_ff, qz_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [23:0] c00_ff, c00_in, c10_ff, c10_in, c01_ff, c01_in, c11_ff, c11_in;
   logic signed [41:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [43:0]        a_ff, a_in, b_ff, b_in;
   logic signed [61:0] pt_ff, pt_in;
   logic signed [23:0] max_ff, max_in, min_ff, min_in;
   logic               any_ff, any_in;
   logic               rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [23:0]        rsp_height_ff, rsp_height_in;

   logic [15:0]        sp_eff;
   logic [24:0]        ext;
   logic [16:0]        trial_x, trial_z;
   logic               ge_x, ge_z, edge_hit;
   logic [IDXW-1:0]    ix, iz;
   logic [AW-1:0]      base_addr, row_addr;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [23:0]        ram_wdata, ram_rdata;
   logic signed [24:0] diff_c_a, diff_c_b, edit_sum;
   logic signed [23:0] edit_val;
   logic signed [44:0] diff_ab;
   logic [63:0]        t_sum;

   hts_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // tile extent and divider step
   assign sp_eff    = (spacing == '0) ? 16'd1 : spacing;
   assign ext       = 25'(GRID_CELLS * int'(sp_eff));
   assign trial_x   = {remx_ff, shx_ff[QW-1]};
   assign trial_z   = {remz_ff, shz_ff[QW-1]};
   assign ge_x      = (trial_x >= {1'b0, sp_eff});
   assign ge_z      = (trial_z >= {1'b0, sp_eff});
   assign ix        = qx_ff[QW-1:16];
   assign iz        = qz_ff[QW-1:16];
   assign edge_hit  = (ix == IDXW'(GRID_CELLS)) || (iz == IDXW'(GRID_CELLS));
   assign base_addr = AW'(int'(ix) * SIDE + int'(iz));
   assign row_addr  = AW'(int'(q_item.row) * SIDE + int'(q_item.col));

   // blend arithmetic
   assign diff_c_a = {c10_ff[23], c10_ff} - {c00_ff[23], c00_ff};
   assign diff_c_b = {c11_ff[23], c11_ff} - {c01_ff[23], c01_ff};
   assign diff_ab  = $signed({b_ff[43], b_ff}) - $signed({a_ff[43], a_ff});
   assign t_sum    = {{4{a_ff[43]}}, a_ff, 16'h0} + {{2{pt_ff[61]}}, pt_ff}
                   + 64'h0000_0000_8000_0000;

   // edit sum with saturation
   assign edit_sum = {ram_rdata[23], ram_rdata} + {lvl_ff[23], lvl_ff};
   assign edit_val = (edit_sum[24] != edit_sum[23])
                   ? (edit_sum[24] ? 24'sh800000 : 24'sh7FFFFF) : edit_sum[23:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      lvl_in        = lvl_ff;
      dx_in         = dx_ff;
      dz_in         = dz_ff;
      remx_in       = remx_ff;
      remz_in       = remz_ff;
      shx_in        = shx_ff;
      shz_in        = shz_ff;
      qx_in         = qx_ff;
      qz_in         = qz_ff;
      cnt_in        = cnt_ff;
      c00_in        = c00_ff;
      c10_in        = c10_ff;
      c01_in        = c01_ff;
      c11_in        = c11_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pt_in         = pt_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      any_in        = any_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_height_in = rsp_height_ff;
      q_pop         = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = base_addr;
      ram_wdata     = edit_val;
      ram_raddr     = base_addr;

      unique case (state_ff)
         hts_pkg::ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop  = 1'b1;
               op_in  = q_item.op;
               lvl_in = q_item.level;
               dx_in  = {q_item.pos_x[23], q_item.pos_x} - {origin_x[23], origin_x};
               dz_in  = {q_item.pos_z[23], q_item.pos_z} - {origin_z[23], origin_z};
               case (q_item.op) inside
                  hts_pkg::OP_WRITE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_hit_in    = q_item.wr_ok;
                     rsp_height_in = '0;
                     if (q_item.wr_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = row_addr;
                        ram_wdata = q_item.level;
                        if (!any_ff) begin
                           max_in = q_item.level;
                           min_in = q_item.level;
                           any_in = 1'b1;
                        end else if (q_item.level > max_ff) begin
                           max_in = q_item.level;
                        end else if (q_item.level < min_ff) begin
                           min_in = q_item.level;
                        end
                     end
                  end
                  hts_pkg::OP_EDIT, hts_pkg::OP_QUERY: begin
                     state_in = hts_pkg::ST_CHECK;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_hit_in    = 1'b0;
                     rsp_height_in = '0;
                  end
               endcase
            end
         end
         hts_pkg::ST_CHECK: begin
            if (!dx_ff[24] && !dz_ff[24] && (dx_ff <= ext) && (dz_ff <= ext)) begin
               remx_in  = dx_ff[IDXW+15:IDXW];
               remz_in  = dz_ff[IDXW+15:IDXW];
               shx_in   = {dx_ff[IDXW-1:0], 16'h0};
               shz_in   = {dz_ff[IDXW-1:0], 16'h0};
               cnt_in   = CW'(QW);
               state_in = hts_pkg::ST_DIV;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_height_in = '0;
               state_in      = hts_pkg::ST_IDLE;
            end
         end
         hts_pkg::ST_DIV: begin
            remx_in = ge_x ? 16'(trial_x - {1'b0, sp_eff}) : trial_x[15:0];
            remz_in = ge_z ? 16'(trial_z - {1'b0, sp_eff}) : trial_z[15:0];
            shx_in  = {shx_ff[QW-2:0], 1'b0};
            shz_in  = {shz_ff[QW-2:0], 1'b0};
            qx_in   = {qx_ff[QW-2:0], ge_x};
            qz_in   = {qz_ff[QW-2:0], ge_z};
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = hts_pkg::ST_RD0;
            end
         end
         hts_pkg::ST_RD0: begin
            state_in = hts_pkg::ST_RD1;
         end
         hts_pkg::ST_RD1: begin
            c00_in = ram_rdata;
            if (op_ff == hts_pkg::OP_EDIT) begin
               ram_we        = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b1;
               rsp_height_in = '0;
               if (edit_val > max_ff) begin
                  max_in = edit_val;
               end else if (edit_val < min_ff) begin
                  min_in = edit_val;
               end
               state_in = hts_pkg::ST_IDLE;
            end else if (edge_hit) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = 1'b1;
               rsp_height_in = ram_rdata;
               state_in      = hts_pkg::ST_IDLE;
            end else begin
               ram_raddr = base_addr + AW'(SIDE);
               state_in  = hts_pkg::ST_RD2;
            end
         end
         hts_pkg::ST_RD2: begin
            c10_in    = ram_rdata;
            ram_raddr = base_addr + AW'(1);
            state_in  = hts_pkg::ST_RD3;
         end
         hts_pkg::ST_RD3: begin
            c01_in    = ram_rdata;
            ram_raddr = base_addr + AW'(SIDE + 1);
            state_in  = hts_pkg::ST_RD4;
         end
         hts_pkg::ST_RD4: begin
            c11_in   = ram_rdata;
            state_in = hts_pkg::ST_MULA;
         end
         hts_pkg::ST_MULA: begin
            pa_in    = diff_c_a * $signed({1'b0, qx_ff[15:0]});
            state_in = hts_pkg::ST_MULB;
         end
         hts_pkg::ST_MULB: begin
            pb_in    = diff_c_b * $signed({1'b0, qx_ff[15:0]});
            state_in = hts_pkg::ST_SUMAB;
         end
         hts_pkg::ST_SUMAB: begin
            a_in     = {{4{c00_ff[23]}}, c00_ff, 16'h0} + {{2{pa_ff[41]}}, pa_ff};
            b_in     = {{4{c01_ff[23]}}, c01_ff, 16'h0} + {{2{pb_ff[41]}}, pb_ff};
            state_in = hts_pkg::ST_MULT;
         end
         hts_pkg::ST_MULT: begin
            pt_in    = diff_ab * $signed({1'b0, qz_ff[15:0]});
            state_in = hts_pkg::ST_DONE;
         end
         hts_pkg::ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = 1'b1;
            rsp_height_in = t_sum[55:32];
            state_in      = hts_pkg::ST_IDLE;
         end
         default: begin
            state_in = hts_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hts_pkg::ST_IDLE;
         max_ff       <= '0;
         min_ff       <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      lvl_ff        <= lvl_in;
      dx_ff         <= dx_in;
      dz_ff         <= dz_in;
      remx_ff       <= remx_in;
      remz_ff       <= remz_in;
      shx_ff        <= shx_in;
      shz_ff        <= shz_in;
      qx_ff         <= qx_in;
      qz_ff         <= qz_in;
      cnt_ff        <= cnt_in;
      c00_ff        <= c00_in;
      c10_ff        <= c10_in;
      c01_ff        <= c01_in;
      c11_ff        <= c11_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      pt_ff         <= pt_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_height_ff <= rsp_height_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {min_ff, max_ff, rsp_height_ff};
   assign rsp_tuser  = rsp_hit_ff;

   `ASSERT_IMPL(a_pop_slot_free, clock, reset, q_pop, !rsp_valid_ff, "item taken while a result waits")
   `ASSERT_IMPL(a_max_ge_min, clock, reset, 1'b1, max_ff >= min_ff, "tracked maximum below minimum")
   `ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, rsp_height_ff == '0, "miss with nonzero height")
   `ASSERT_NEXT(a_div_to_read, clock, reset, (state_ff == hts_pkg::ST_DIV) && (cnt_ff == CW'(1)), state_ff == hts_pkg::ST_RD0, "divider did not hand over")

endmodule

>>> hdl/heightmap_tile_sampler_core.sv
// Flow: a write or unused opcode is answered from idle, a miss after the range check, an
//   edit or far-edge query after the divider and one read, a full query after four reads
//   and the blend. QW = clog2(GRID_CELLS+1) + 16 is the divider length (23 by default).
// Throughput: one item at a time in the back; a two-word queue takes new items meanwhile.
// Reset: synchronous, active high; clears queue, sequencer, min/max tracking and config.
//   The grid memory is not cleared; points read before written are undefined.
// ----------------------------------------------------------------------------
// heightmap_tile_sampler_core
// Terrain tile sampler: grid writes, saturating edits and bilinear queries.
// ----------------------------------------------------------------------------
module heightmap_tile_sampler_core #(
   parameter int GRID_CELLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // grid_row[6:0], grid_col[13:7], pos_x[37:14], pos_z[61:38], level[85:62]
   input  logic [87:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // height_out[23:0], highest[47:24], lowest[71:48]
   output logic [71:0] rsp_tdata,
   // hit[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic signed [23:0] origin_x_ff, origin_z_ff;
   logic [15:0]        spacing_ff;
   logic               csr_wr;
   logic               q_valid, q_pop;
   hts_pkg::item_type  q_item;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_z_ff <= '0;
         spacing_ff  <= 16'd1280;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            hts_pkg::REG_ORIGIN_X: origin_x_ff <= csr_pwdata[23:0];
            hts_pkg::REG_ORIGIN_Z: origin_z_ff <= csr_pwdata[23:0];
            hts_pkg::REG_SPACING:  spacing_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         hts_pkg::REG_ORIGIN_X: csr_prdata = {{8{origin_x_ff[23]}}, origin_x_ff};
         hts_pkg::REG_ORIGIN_Z: csr_prdata = {{8{origin_z_ff[23]}}, origin_z_ff};
         hts_pkg::REG_SPACING:  csr_prdata = {16'h0, spacing_ff};
         default:               csr_prdata = '0;
      endcase
   end

   hts_front #(.GRID_CELLS(GRID_CELLS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item)
   );

   hts_back #(.GRID_CELLS(GRID_CELLS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .origin_x   (origin_x_ff),
      .origin_z   (origin_z_ff),
      .spacing    (spacing_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> test/tb_heightmap_tile_sampler_core.sv
// ----------------------------------------------------------------------------
// tb_heightmap_tile_sampler_core
// Self-checking bench for the terrain tile sampler. A queue of request words
// feeds a stream driver; every accepted word is run through an in-bench model
// of the tile (grid, min/max tracking, bilinear blend) and the predicted
// sample is compared field by field with each accepted response word. The
// tile origin and spacing are reprogrammed between phases, and both stream
// sides stall at random, including one long response hold-off.
// ----------------------------------------------------------------------------
module tb_heightmap_tile_sampler_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = 64;
   localparam int SIDE = CELLS + 1;
   // rows and columns 0..LOADED plus the far edge are loaded before any hit
   localparam int LOADED = 16;
   localparam int H_MAX = 8388607;
   localparam int H_MIN = -8388608;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0] op;
      logic [6:0] row;
      logic [6:0] col;
      logic signed [23:0] px;
      logic signed [23:0] pz;
      logic signed [23:0] lvl;
   } req_word_type;

   typedef struct {
      logic signed [23:0] height;
      logic hit;
      logic signed [23:0] highest;
      logic signed [23:0] lowest;
   } sample_type;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [87:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [71:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   // tile model
   int tile_grid [SIDE*SIDE];
   int top_height, floor_height;
   bit tile_loaded;
   int org_x, org_z, step_size;

   req_word_type pending_words[$];
   sample_type expected_samples[$];
   int errors;
   int req_idle_pct, rsp_idle_pct;
   int hold_left;
   bit hold_go, hold_taken;
   bit req_accepted;

   heightmap_tile_sampler_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   function automatic bit locate_cell(input int px, input int pz, output int ix,
                                      output int iz, output longint fx, output longint fz);
      longint sp, dx, dz, ext;
      sp = (step_size == 0) ? 1 : step_size;
      dx = longint'(px) - org_x;
      dz = longint'(pz) - org_z;
      ext = CELLS * sp;
      if (dx < 0 || dx > ext || dz < 0 || dz > ext) return 1'b0;
      ix = int'(dx / sp);
      iz = int'(dz / sp);
      fx = ((dx - ix * sp) << 16) / sp;
      fz = ((dz - iz * sp) << 16) / sp;
      return 1'b1;
   endfunction

   function automatic void track_height(int v);
      if (v > top_height) top_height = v;
      else if (v < floor_height) floor_height = v;
   endfunction

   // Advance the tile model by one request and return the sample it yields.
   function automatic sample_type sample_tile(req_word_type w);
      sample_type s;
      int ix, iz, a;
      longint fx, fz, ca, cb, t, v;
      s.height = '0;
      s.hit = 1'b0;
      if (w.op == hts_pkg::OP_WRITE) begin
         if (w.row <= CELLS && w.col <= CELLS) begin
            tile_grid[w.row*SIDE + w.col] = w.lvl;
            if (!tile_loaded) begin
               top_height = w.lvl;
               floor_height = w.lvl;
               tile_loaded = 1'b1;
            end else begin
               track_height(w.lvl);
            end
            s.hit = 1'b1;
         end
      end else if (w.op == hts_pkg::OP_EDIT) begin
         if (locate_cell(w.px, w.pz, ix, iz, fx, fz)) begin
            a = ix*SIDE + iz;
            v = longint'(tile_grid[a]) + w.lvl;
            if (v > H_MAX) v = H_MAX;
            if (v < H_MIN) v = H_MIN;
            tile_grid[a] = int'(v);
            track_height(int'(v));
            s.hit = 1'b1;
         end
      end else if (w.op == hts_pkg::OP_QUERY) begin
         if (locate_cell(w.px, w.pz, ix, iz, fx, fz)) begin
            s.hit = 1'b1;
            if (ix == CELLS || iz == CELLS) begin
               s.height = 24'(tile_grid[ix*SIDE + iz]);
            end else begin
               ca = longint'(tile_grid[ix*SIDE + iz]) * (65536 - fx)
                  + longint'(tile_grid[(ix+1)*SIDE + iz]) * fx;
               cb = longint'(tile_grid[ix*SIDE + iz + 1]) * (65536 - fx)
                  + longint'(tile_grid[(ix+1)*SIDE + iz + 1]) * fx;
               t = ca * (65536 - fz) + cb * fz + (longint'(1) << 31);
               s.height = 24'(t >>> 32);
            end
         end
      end
      s.highest = 24'(top_height);
      s.lowest = 24'(floor_height);
      return s;
   endfunction

   // Sample both channels at the rising edge: predict on request, check on response.
   always @(posedge clock) begin
      req_word_type w;
      sample_type e;
      req_accepted = req_tvalid && req_tready && !reset;
      if (req_accepted) begin
         w.op = req_tuser;
         w.row = req_tdata[6:0];
         w.col = req_tdata[13:7];
         w.px = req_tdata[37:14];
         w.pz = req_tdata[61:38];
         w.lvl = req_tdata[85:62];
         expected_samples.insert(expected_samples.size(), sample_tile(w));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: response word with nothing expected: %h/%b", $time,
                     rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = expected_samples.pop_front();
            if (rsp_tdata[23:0] !== e.height) begin
               $display("%0t: height exp %h got %h", $time, e.height, rsp_tdata[23:0]);
               errors++;
            end
            if (rsp_tuser !== e.hit) begin
               $display("%0t: hit exp %b got %b", $time, e.hit, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[47:24] !== e.highest) begin
               $display("%0t: highest exp %h got %h", $time, e.highest, rsp_tdata[47:24]);
               errors++;
            end
            if (rsp_tdata[71:48] !== e.lowest) begin
               $display("%0t: lowest exp %h got %h", $time, e.lowest, rsp_tdata[71:48]);
               errors++;
            end
         end
      end
   end

   // Request driver: hold the word until taken, then advance or idle.
   always @(negedge clock) begin
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (pending_words.size() > 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            w = pending_words.pop_front();
            req_tdata <= {2'b00, w.lvl, w.pz, w.px, w.col, w.row};
            req_tuser <= w.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: long hold-off when requested, random stalls otherwise.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic csr_write(input logic [1:0] idx, input int value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         hts_pkg::REG_ORIGIN_X: org_x = $signed(value[23:0]);
         hts_pkg::REG_ORIGIN_Z: org_z = $signed(value[23:0]);
         default: step_size = value[15:0];
      endcase
   endtask

   task automatic set_tile(int ox, int oz, int sp);
      csr_write(hts_pkg::REG_ORIGIN_X, ox);
      csr_write(hts_pkg::REG_ORIGIN_Z, oz);
      csr_write(hts_pkg::REG_SPACING, sp);
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_tvalid || expected_samples.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic void push_word(logic [1:0] op, int row, int col, int px, int pz,
                                     int lvl);
      req_word_type w;
      w.op = op;
      w.row = 7'(row);
      w.col = 7'(col);
      w.px = 24'(px);
      w.pz = 24'(pz);
      w.lvl = 24'(lvl);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic int rand_level();
      return int'($urandom() << 8) >>> 8;
   endfunction

   // Pick a world coordinate: hits stay on the loaded part or the far edge.
   function automatic int pick_pos(int org);
      longint sp, ext, lim, v, miss;
      int r;
      sp = step_size;
      ext = CELLS * sp;
      lim = LOADED * sp;
      if (org > H_MIN) miss = longint'(org) - 1;
      else if (longint'(org) + ext < H_MAX) miss = longint'(org) + ext + 1;
      else miss = org;
      r = $urandom_range(0, 99);
      if (r < 10) v = rand_level();
      else if (r < 15) v = ($urandom_range(0, 1) != 0) ? longint'(org) - 1
                                                        : longint'(org) + ext + 1;
      else if (r < 22) v = longint'(org) + ext;
      else if (r < 40) v = longint'(org) + longint'($urandom_range(0, LOADED - 1)) * sp;
      else v = longint'(org) + longint'($urandom()) % lim;
      // move hits on unloaded rows or columns off the tile
      if (v >= org && v < longint'(org) + ext && v - org >= lim) v = miss;
      if (v > H_MAX || v < H_MIN) v = miss;
      return int'(v);
   endfunction

   task automatic push_random(int n);
      int r, lvl;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            push_word(hts_pkg::OP_WRITE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                      : $urandom_range(0, CELLS), ($urandom_range(0, 9) == 0)
                      ? $urandom_range(0, 127) : $urandom_range(0, CELLS), rand_level(),
                      rand_level(), rand_level());
         end else if (r < 40) begin
            lvl = ($urandom_range(0, 4) == 0) ? rand_level()
                  : int'($urandom_range(0, 8191)) - 4096;
            push_word(hts_pkg::OP_EDIT, $urandom_range(0, 127), $urandom_range(0, 127),
                      pick_pos(org_x), pick_pos(org_z), lvl);
         end else if (r < 95) begin
            push_word(hts_pkg::OP_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                      pick_pos(org_x), pick_pos(org_z), rand_level());
         end else begin
            push_word(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                      rand_level(), rand_level(), rand_level());
         end
      end
   endtask

   initial begin
      int ext;
      errors = 0;
      hold_go = 1'b0;
      req_idle_pct = 24;
      rsp_idle_pct = 75;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tile_grid = '{default: 0};
      top_height = 0;
      floor_height = 0;
      tile_loaded = 1'b0;
      org_x = 0;
      org_z = 0;
      step_size = 1280;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Phase A: load the tile, directed corners, then random traffic.
      set_tile(-1000, 2560, 1280);
      ext = CELLS * step_size;
      push_word(OP_UNUSED, 127, 127, H_MAX, H_MIN, H_MAX);
      push_word(hts_pkg::OP_WRITE, CELLS + 1, 0, 0, 0, 5);
      push_word(hts_pkg::OP_WRITE, 127, 127, 0, 0, 5);
      push_word(hts_pkg::OP_WRITE, 0, CELLS + 1, 0, 0, 5);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x - 1, org_z, 0);
      push_word(hts_pkg::OP_EDIT, 0, 0, org_x + ext + 1, org_z + ext, 100);
      push_word(hts_pkg::OP_QUERY, 0, 0, H_MIN, H_MAX, 0);
      for (int r = 0; r <= CELLS; r++)
         for (int c = 0; c <= CELLS; c++)
            if ((r <= LOADED || r == CELLS) && (c <= LOADED || c == CELLS))
               push_word(hts_pkg::OP_WRITE, r, c, 0, 0, (r == 0 && c == 0) ? H_MAX
                         : (r == 0 && c == 1) ? H_MIN : rand_level());
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x, org_z, 0);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x + ext, org_z + 640, 0);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x + 700, org_z + ext, 0);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x + ext, org_z + ext, 0);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x + 1279, org_z + 1279, 0);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x + 640, org_z + 640, 0);
      push_word(hts_pkg::OP_EDIT, 0, 0, org_x, org_z, H_MAX);
      push_word(hts_pkg::OP_EDIT, 0, 0, org_x + 5, org_z + 1280, H_MIN);
      push_word(hts_pkg::OP_EDIT, 0, 0, org_x + ext, org_z + ext, 7);
      push_word(hts_pkg::OP_QUERY, 0, 0, org_x + 1, org_z + 1281, 0);
      push_random(380);
      wait_drained();

      // Phase B: widest spacing at the lowest origin, long response hold-off.
      req_idle_pct = 75;
      rsp_idle_pct = 24;
      set_tile(H_MIN, H_MIN, 65535);
      @(posedge clock);
      hold_go = 1'b1;
      push_random(300);
      wait_drained();

      // Phase C: unit spacing, no stalls.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_tile(H_MAX - 64, 12345, 1);
      push_random(300);
      wait_drained();

      // Phase D: origin at the top of the range, tile mostly off the map.
      set_tile(H_MAX, H_MAX, 300);
      push_word(hts_pkg::OP_QUERY, 0, 0, H_MAX, H_MAX, 0);
      push_word(hts_pkg::OP_EDIT, 0, 0, H_MAX, H_MAX, -3);
      push_random(100);
      wait_drained();

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hts_pkg.sv
hdl/hts_ram.sv
hdl/hts_front.sv
hdl/hts_back.sv
hdl/heightmap_tile_sampler_core.sv
test/tb_heightmap_tile_sampler_core.sv
